// File: rtl/core/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared constants and types of the rate-monotonic tick scheduler: table
// size, time width, command codes and the layout of one task table entry.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int TIME_BITS = 32;

  localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 4;
  localparam int WORK_W  = 16;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  typedef struct packed {
    logic [WORK_W-1:0]    burst;
    logic [WORK_W-1:0]    period;
    logic [WORK_W-1:0]    remaining;
    logic [TIME_BITS-1:0] release_time;
  } task_entry_t;

endpackage

// File: rtl/core/rate_monotonic_tick_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// Preemptive rate-monotonic scheduler over a table of periodic tasks.
//
// Channels: request (command, slot, burst_time, task_period) and result
// (running_valid, running_slot, job_done, time_saturated), each with valid
// and stall; a transfer happens when valid is high and stall is low.
// task_count is written through cfg_write/cfg_data; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// All task state sits in one synchronous task table with a registered
// read port, read and written back by a small sequencer; one request is in
// work at a time. A load or unknown command goes straight to its result;
// a tick reads each active slot once, with active = task_count capped at
// MAX_TASKS; a restart sweep reloads every entry. The next request is
// taken in the cycle after the previous result is issued.
// A finished result sits in an output register, so the next request is
// accepted while the result waits under stall; a result that cannot be
// delivered holds the sequencer until the output register frees.
// Reset clears time, task_count and the per-entry valid bits; entries not
// yet written read as zero.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rmts_pkg::COUNT_W-1:0] cfg_data,
  input  logic                        request_valid,
  output logic                        request_stall,
  input  logic [1:0]                  command,
  input  logic [rmts_pkg::SLOT_W-1:0] slot,
  input  logic [rmts_pkg::WORK_W-1:0] burst_time,
  input  logic [rmts_pkg::WORK_W-1:0] task_period,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        running_valid,
  output logic [rmts_pkg::SLOT_W-1:0] running_slot,
  output logic                        job_done,
  output logic                        time_saturated
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  state_t state;

  rmts_pkg::task_entry_t mem [rmts_pkg::MAX_TASKS];
  logic [rmts_pkg::MAX_TASKS-1:0] ent_vld;

  logic [rmts_pkg::COUNT_W-1:0]   task_count;
  logic [rmts_pkg::TIME_BITS-1:0] cur_time;

  logic [rmts_pkg::CNT_W-1:0] rd_idx;
  logic                       eval_vld;
  logic [rmts_pkg::IDX_W-1:0] eval_idx;
  rmts_pkg::task_entry_t      rd_q;
  logic                       rd_ent_vld;

  logic                       found;
  logic [rmts_pkg::IDX_W-1:0] best_idx;
  rmts_pkg::task_entry_t      best_ent;

  logic                        pend_run;
  logic [rmts_pkg::SLOT_W-1:0] pend_slot;
  logic                        pend_done;

  rmts_pkg::command_t cmd;
  logic [rmts_pkg::CNT_W-1:0] active;
  logic                       req_accept;
  logic                       rd_issue;
  logic [rmts_pkg::IDX_W-1:0] rd_addr;
  rmts_pkg::task_entry_t      eff;
  logic                       eff_ready;
  logic                       scan_done;
  logic                       sweep_done;
  logic                       slot_in_range;

  logic                       mem_we;
  logic [rmts_pkg::IDX_W-1:0] wr_addr;
  rmts_pkg::task_entry_t      wr_data;

  logic [rmts_pkg::WORK_W-1:0]  rem_dec;
  logic                         job_end;
  logic [rmts_pkg::TIME_BITS:0] rel_sum;
  rmts_pkg::task_entry_t        upd_ent;
  logic                         out_free;

  assign cmd           = rmts_pkg::command_t'(command);
  assign request_stall = (state != ST_IDLE);
  assign req_accept    = request_valid && !request_stall;
  assign out_free      = !result_valid || !result_stall;
  assign slot_in_range = (32'(slot) < rmts_pkg::MAX_TASKS);

  assign active = (32'(task_count) > rmts_pkg::MAX_TASKS)
                ? rmts_pkg::CNT_W'(rmts_pkg::MAX_TASKS)
                : rmts_pkg::CNT_W'(task_count);

  assign rd_issue = ((state == ST_SCAN) && (rd_idx < active)) ||
                    ((state == ST_SWEEP) &&
                     (32'(rd_idx) < rmts_pkg::MAX_TASKS));
  assign rd_addr  = rd_idx[rmts_pkg::IDX_W-1:0];

  assign eff       = rd_ent_vld ? rd_q : '0;
  assign eff_ready = (eff.remaining != '0) && (cur_time >= eff.release_time);
  assign scan_done  = (state == ST_SCAN) && !rd_issue && !eval_vld;
  assign sweep_done = (state == ST_SWEEP) && !rd_issue && !eval_vld;

  // completion of one unit of work on the chosen task
  assign rem_dec = best_ent.remaining - 1'b1;
  assign job_end = (rem_dec == '0);
  assign rel_sum = {1'b0, best_ent.release_time} +
                   (rmts_pkg::TIME_BITS + 1)'(best_ent.period);

  always_comb begin
    upd_ent = best_ent;
    if (job_end) begin
      upd_ent.remaining    = best_ent.burst;
      upd_ent.release_time = rel_sum[rmts_pkg::TIME_BITS]
                           ? rmts_pkg::TIME_MAX
                           : rel_sum[rmts_pkg::TIME_BITS-1:0];
    end else begin
      upd_ent.remaining = rem_dec;
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = eval_idx;
    wr_data = '0;
    if (req_accept && (cmd == rmts_pkg::CMD_LOAD)) begin
      mem_we         = slot_in_range;
      wr_addr        = rmts_pkg::IDX_W'(slot);
      wr_data.burst  = burst_time;
      wr_data.period = task_period;
    end else if ((state == ST_SWEEP) && eval_vld) begin
      mem_we            = 1'b1;
      wr_data.burst     = eff.burst;
      wr_data.period    = eff.period;
      wr_data.remaining = eff.burst;
    end else if (scan_done && found) begin
      mem_we  = 1'b1;
      wr_addr = best_idx;
      wr_data = upd_ent;
    end
  end

  // task table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ent_vld        <= '0;
      task_count     <= '0;
      cur_time       <= '0;
      rd_idx         <= '0;
      eval_vld       <= 1'b0;
      eval_idx       <= '0;
      rd_ent_vld     <= 1'b0;
      found          <= 1'b0;
      best_idx       <= '0;
      best_ent       <= '0;
      pend_run       <= 1'b0;
      pend_slot      <= '0;
      pend_done      <= 1'b0;
      result_valid   <= 1'b0;
      running_valid  <= 1'b0;
      running_slot   <= '0;
      job_done       <= 1'b0;
      time_saturated <= 1'b0;
    end else begin
      if (cfg_write) begin
        task_count <= cfg_data;
      end
      if (mem_we) begin
        ent_vld[wr_addr] <= 1'b1;
      end
      if (result_valid && !result_stall && (state != ST_RESULT)) begin
        result_valid <= 1'b0;
      end

      rd_ent_vld <= ent_vld[rd_addr];
      eval_vld   <= rd_issue;
      eval_idx   <= rd_addr;
      if (rd_issue) begin
        rd_idx <= rd_idx + 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            rd_idx    <= '0;
            found     <= 1'b0;
            pend_run  <= 1'b0;
            pend_slot <= '0;
            pend_done <= 1'b0;
            unique case (cmd)
              rmts_pkg::CMD_TICK:    state <= ST_SCAN;
              rmts_pkg::CMD_RESTART: begin
                cur_time <= '0;
                state    <= ST_SWEEP;
              end
              rmts_pkg::CMD_LOAD:    state <= ST_RESULT;
              rmts_pkg::CMD_NONE:    state <= ST_RESULT;
            endcase
          end
        end
        ST_SCAN: begin
          if (eval_vld && eff_ready && (!found || (eff.period < best_ent.period))) begin
            found    <= 1'b1;
            best_idx <= eval_idx;
            best_ent <= eff;
          end
          if (scan_done) begin
            pend_run  <= found;
            pend_slot <= found ? rmts_pkg::SLOT_W'(best_idx) : '0;
            pend_done <= found && job_end;
            if (cur_time != rmts_pkg::TIME_MAX) begin
              cur_time <= cur_time + 1'b1;
            end
            state <= ST_RESULT;
          end
        end
        ST_SWEEP: begin
          if (sweep_done) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            running_valid  <= pend_run;
            running_slot   <= pend_slot;
            job_done       <= pend_done;
            time_saturated <= (cur_time == rmts_pkg::TIME_MAX);
            state          <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_pick_has_work: assert property (@(posedge clk) disable iff (rst)
    (scan_done && found) |-> (best_ent.remaining != '0))
    else $error("scheduled task has no work left");

  a_sweep_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SWEEP) && mem_we && rd_issue) |-> (wr_addr != rd_addr))
    else $error("sweep writes the entry being read");

  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_RESULT))
    else $error("result raised outside result state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= active))
    else $error("scan index past active slots");

endmodule
